// ----- hdl/wmd_pkg.sv -----
// shared types and constants for the windowed motion detector
`default_nettype none

package wmd_pkg;

   // input beat: one three-axis sample
   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_type;

   // output beat: window decision
   typedef struct packed {
      logic motion_detected;
      logic window_done;
   } rsp_type;

   // register indexes and widths
   localparam int CSR_WIDTH = 16;
   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_WINDOW    = 1'b1;
   localparam logic [15:0] THRESHOLD_RESET = 16'd8192;
   localparam logic [7:0]  WINDOW_RESET    = 8'd16;

   // operand select of the shared multiplier
   typedef enum logic [1:0] {
      MUL_X,
      MUL_Y,
      MUL_Z,
      MUL_THR
   } mul_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        capture;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        acc_add;
      logic        root_init;
      logic        root_step;
      logic        update;
      logic        finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic root_last;
   } sts_type;

   // magnitude of a signed 16-bit value, 17 bits so that -32768 fits
   function automatic logic [16:0] abs17(input logic signed [15:0] v);
      logic [16:0] ext;
      ext = {v[15], v};
      return v[15] ? (~ext + 17'd1) : ext;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/wmd_ctrl.sv -----
// sequencing state machine of the motion detector
`default_nettype none

module wmd_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output wmd_pkg::cmd_type     cmd,
   input  wire wmd_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MULX,
      S_MULY,
      S_MULZ,
      S_ADD,
      S_ROOT,
      S_UPD,
      S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // commands and next state
   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = wmd_pkg::MUL_X;
      state_in     = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = S_MULX;
         end
         S_MULX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = wmd_pkg::MUL_X;
            state_in    = S_MULY;
         end
         S_MULY: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = wmd_pkg::MUL_Y;
            cmd.acc_load = 1'b1;
            state_in     = S_MULZ;
         end
         S_MULZ: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = wmd_pkg::MUL_Z;
            cmd.acc_add = 1'b1;
            state_in    = S_ADD;
         end
         S_ADD: begin
            cmd.root_init = 1'b1;
            state_in      = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (sts.root_last) state_in = S_UPD;
         end
         S_UPD: begin
            cmd.update  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = wmd_pkg::MUL_THR;
            state_in    = S_FIN;
         end
         S_FIN: begin
            // wait for the output slot to free up
            cmd.finish = !rsp_valid_ff || rsp_ready;
            if (cmd.finish) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output beat holding register
   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // an accepted beat makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while busy");

   // a result is only written into a free output slot
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("output beat overwritten");

   // the root iteration runs until its last step
   a_root_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.root_step && !sts.root_last |=> cmd.root_step)
      else $error("root iteration cut short");
`endif

endmodule

`default_nettype wire

// ----- hdl/wmd_datapath.sv -----
// squares, square root, window sum and decision registers
`default_nettype none

module wmd_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire wmd_pkg::req_type                  req_data,
   input  wire wmd_pkg::cmd_type                  cmd,
   output wmd_pkg::sts_type                       sts,
   input  wire logic                              csr_we,
   input  wire logic                              csr_index,
   input  wire logic [wmd_pkg::CSR_WIDTH-1:0]     csr_wdata,
   output wmd_pkg::rsp_type                       rsp_data
);

   logic [16:0] ax_ff, ay_ff, az_ff;
   logic [31:0] prod_ff, acc_ff;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] probe_ff, probe_in;
   logic [15:0] prev_ff;
   logic [23:0] sum_ff, sum_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] thr_ff;
   logic [7:0]  wl_ff;
   wmd_pkg::rsp_type rsp_ff;

   logic [16:0] mul_a, mul_b;
   logic [33:0] mul_full;
   logic [31:0] trial;
   logic [15:0] mag, delta;
   logic [24:0] sum_wide;
   logic [26:0] lhs, rhs;
   logic        close;

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         wmd_pkg::MUL_X: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         wmd_pkg::MUL_Y: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         wmd_pkg::MUL_Z: begin
            mul_a = az_ff;
            mul_b = az_ff;
         end
         wmd_pkg::MUL_THR: begin
            mul_a = {1'b0, thr_ff};
            mul_b = {9'b0, wl_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_full = mul_a * mul_b;

   // one bit of the root per step
   assign trial = root_ff + probe_ff;
   always_comb begin
      rem_in   = rem_ff;
      root_in  = root_ff;
      probe_in = probe_ff;
      if (cmd.root_init) begin
         rem_in   = acc_ff + prod_ff;
         root_in  = '0;
         probe_in = 32'h4000_0000;
      end else if (cmd.root_step) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + probe_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         probe_in = probe_ff >> 2;
      end
   end
   assign sts.root_last = probe_ff[0];

   // change from the last magnitude, saturating window sum
   assign mag      = root_ff[15:0];
   assign delta    = (mag >= prev_ff) ? (mag - prev_ff) : (prev_ff - mag);
   assign sum_wide = {1'b0, sum_ff} + {9'b0, delta};

   // window decision: 5*sum > 4*threshold*window
   assign close = (count_ff >= wl_ff);
   assign lhs   = {3'b0, sum_ff} + {1'b0, sum_ff, 2'b0};
   assign rhs   = {1'b0, prod_ff[23:0], 2'b0};

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (cmd.update) begin
         sum_in   = sum_wide[24] ? 24'hFF_FFFF : sum_wide[23:0];
         count_in = count_ff + 8'd1;
      end else if (cmd.finish && close) begin
         sum_in   = '0;
         count_in = '0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ax_ff <= wmd_pkg::abs17(req_data.accel_x);
         ay_ff <= wmd_pkg::abs17(req_data.accel_y);
         az_ff <= wmd_pkg::abs17(req_data.accel_z);
      end
      if (cmd.mul_en) prod_ff <= mul_full[31:0];
      if (cmd.acc_load) begin
         acc_ff <= prod_ff;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + prod_ff;
      end
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      probe_ff <= probe_in;
      if (cmd.finish) begin
         rsp_ff.window_done     <= close;
         rsp_ff.motion_detected <= close && (lhs > rhs);
      end
   end

   // window state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
         thr_ff   <= wmd_pkg::THRESHOLD_RESET;
         wl_ff    <= wmd_pkg::WINDOW_RESET;
      end else begin
         if (cmd.update) prev_ff <= mag;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         if (csr_we && csr_index == wmd_pkg::CSR_THRESHOLD) thr_ff <= csr_wdata;
         if (csr_we && csr_index == wmd_pkg::CSR_WINDOW)    wl_ff  <= csr_wdata[7:0];
      end
   end

   assign rsp_data = rsp_ff;

`ifndef ASSERT_OFF
   // a closed window leaves an empty sum and count
   a_window_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && close |=> (sum_ff == '0) && (count_ff == '0))
      else $error("window not cleared");

   // motion is only reported on a closed window
   a_motion_done: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (!rsp_ff.motion_detected || rsp_ff.window_done))
      else $error("motion without window end");

   // the probe bit stays one-hot while the root runs
   a_probe_onehot: assert property (@(posedge clock) disable iff (reset)
      cmd.root_step |-> $onehot(probe_ff))
      else $error("root probe bit lost");
`endif

endmodule

`default_nettype wire

// ----- hdl/windowed_motion_detector.sv -----
// a new sample is accepted only once the previous result is finished;
// each sample runs the 16-step square root and passes through the single
// shared multiplier for the three axis squares and threshold * window
// a finished result waits in the output register while the next sample runs
// reset (synchronous, active high) clears the window state and restores
// threshold 8192 and window length 16
`default_nettype none

module windowed_motion_detector (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire wmd_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output wmd_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [wmd_pkg::CSR_WIDTH-1:0] csr_wdata
);

   wmd_pkg::cmd_type cmd;
   wmd_pkg::sts_type sts;

   // sequencer
   wmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // arithmetic and window state
   wmd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// self-checking testbench for the windowed motion detector
module tb;

   // cycles with no beat on either channel before the run is abandoned
   localparam int IDLE_LIMIT   = 2000;
   // settle time after the last result beat
   localparam int DRAIN_CYCLES = 30;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 110;

   // tracks the window state and holds the decisions still owed by the block
   class motion_scoreboard;
      logic [15:0]      threshold;
      logic [7:0]       window_len;
      logic [15:0]      last_mag;
      logic [23:0]      change_sum;
      logic [7:0]       sample_cnt;
      wmd_pkg::rsp_type pending[$];
      int               errors;

      function new();
         threshold  = wmd_pkg::THRESHOLD_RESET;
         window_len = wmd_pkg::WINDOW_RESET;
         last_mag   = '0;
         change_sum = '0;
         sample_cnt = '0;
         errors     = 0;
      endfunction

      function void write_reg(logic idx, logic [15:0] value);
         if (idx == wmd_pkg::CSR_THRESHOLD) begin
            threshold = value;
         end else begin
            window_len = value[7:0];
         end
      endfunction

      // floor square root of x*x + y*y + z*z, one result bit per pass
      function logic [15:0] magnitude(wmd_pkg::req_type s);
         longint      ax, ay, az;
         logic [63:0] energy;
         logic [63:0] root;
         logic [63:0] trial;
         ax = longint'($signed(s.accel_x));
         ay = longint'($signed(s.accel_y));
         az = longint'($signed(s.accel_z));
         if (ax < 0) ax = -ax;
         if (ay < 0) ay = -ay;
         if (az < 0) az = -az;
         energy = 64'(ax * ax + ay * ay + az * az);
         root = '0;
         for (int i = 15; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= energy) root = trial;
         end
         return root[15:0];
      endfunction

      // accepted sample beat: advance the window and queue its decision
      function void note_sample(wmd_pkg::req_type s);
         logic [15:0]      mag;
         logic [15:0]      change;
         logic [24:0]      widened;
         logic [63:0]      lhs;
         logic [63:0]      rhs;
         wmd_pkg::rsp_type decision;
         mag = magnitude(s);
         change = (mag >= last_mag) ? mag - last_mag : last_mag - mag;
         last_mag = mag;
         widened = {1'b0, change_sum} + {9'd0, change};
         change_sum = widened[24] ? 24'hFFFFFF : widened[23:0];
         sample_cnt = sample_cnt + 8'd1;
         decision = '0;
         // window closes once the count reaches the length, also when the length is zero
         if (sample_cnt >= window_len) begin
            lhs = 64'd5 * 64'(change_sum);
            rhs = 64'd4 * 64'(threshold) * 64'(window_len);
            decision.motion_detected = (lhs > rhs);
            decision.window_done = 1'b1;
            change_sum = '0;
            sample_cnt = '0;
         end
         pending.push_back(decision);
      endfunction

      // accepted result beat: compare with the oldest owed decision
      function void check_result(wmd_pkg::rsp_type got);
         wmd_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $error("unexpected result beat motion_detected=%0b window_done=%0b",
                   got.motion_detected, got.window_done);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.motion_detected !== want.motion_detected) begin
            $error("motion_detected expected %0b actual %0b",
                   want.motion_detected, got.motion_detected);
            errors++;
         end
         if (got.window_done !== want.window_done) begin
            $error("window_done expected %0b actual %0b",
                   want.window_done, got.window_done);
            errors++;
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   wmd_pkg::req_type              req_data;
   logic                          rsp_valid;
   logic                          rsp_ready;
   wmd_pkg::rsp_type              rsp_data;
   logic                          csr_we;
   logic                          csr_index;
   logic [wmd_pkg::CSR_WIDTH-1:0] csr_wdata;

   bit                   send_gaps = 1'b1;
   bit                   recv_gaps = 1'b1;
   int                   rsp_hold;
   int                   idle_cycles;
   motion_scoreboard     board;

   windowed_motion_detector u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // present one sample beat and hold it until accepted, then maybe go quiet
   task automatic send_sample(wmd_pkg::req_type s);
      int gap;
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (!req_ready);
      board.note_sample(s);
      if (send_gaps && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_xyz(int x, int y, int z);
      wmd_pkg::req_type s;
      s.accel_x = 16'(x);
      s.accel_y = 16'(y);
      s.accel_z = 16'(z);
      send_sample(s);
   endtask

   // hold off the sender until every owed decision has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // both registers are rewritten while the block is idle
   task automatic configure(logic [15:0] thr, logic [7:0] win);
      drain();
      csr_we    <= 1'b1;
      csr_index <= wmd_pkg::CSR_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      csr_index <= wmd_pkg::CSR_WINDOW;
      csr_wdata <= {8'h00, win};
      @(posedge clock);
      csr_we <= 1'b0;
      board.write_reg(wmd_pkg::CSR_THRESHOLD, thr);
      board.write_reg(wmd_pkg::CSR_WINDOW, {8'h00, win});
   endtask

   function automatic logic [15:0] extreme_axis();
      case ($urandom_range(0, 4))
         0:       return 16'h8000;
         1:       return 16'hFFFF;
         2:       return 16'h0000;
         3:       return 16'h0001;
         default: return 16'h7FFF;
      endcase
   endfunction

   // moving samples span the full range, some take extreme axis values, still ones sit near 1 g on z
   function automatic wmd_pkg::req_type random_sample(int busy_pct);
      wmd_pkg::req_type s;
      if ($urandom_range(0, 99) < busy_pct) begin
         s.accel_x = 16'($urandom);
         s.accel_y = 16'($urandom);
         s.accel_z = 16'($urandom);
      end else if ($urandom_range(0, 9) == 0) begin
         s.accel_x = extreme_axis();
         s.accel_y = extreme_axis();
         s.accel_z = extreme_axis();
      end else begin
         s.accel_x = 16'(int'($urandom_range(0, 255)) - 128);
         s.accel_y = 16'(int'($urandom_range(0, 255)) - 128);
         s.accel_z = 16'(8192 + int'($urandom_range(0, 511)) - 256);
      end
      return s;
   endfunction

   // result side: random stall bursts, checks every accepted beat
   initial begin
      rsp_ready = 1'b0;
      rsp_hold  = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
            rsp_hold = $urandom_range(1, 11) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on beats of either channel
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      int          phase;
      int          count;
      int          busy_pct;
      logic [15:0] thr;
      logic [7:0]  win;
      board     = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = wmd_pkg::CSR_THRESHOLD;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: first sample sees a zero previous magnitude
      send_xyz(32767, 32767, 32767);
      send_xyz(-32768, -32768, -32768);
      send_xyz(0, 0, 0);
      send_xyz(-32768, 0, 0);
      send_xyz(1, -1, 1);
      send_xyz(0, 0, 8192);
      send_xyz(0, 0, 8192);
      send_xyz(-1, -1, -1);
      // window shortened below the open count closes on the next sample
      configure(16'd8192, 8'd6);
      send_xyz(12345, -23456, 345);
      // zero threshold: any change is motion, no change is not
      configure(16'd0, 8'd1);
      send_xyz(0, 0, 100);
      send_xyz(0, 0, 100);
      // zero window length closes on every sample
      configure(16'hFFFF, 8'd0);
      send_xyz(0, 0, 0);
      send_xyz(0, 0, 0);
      send_xyz(32767, -32768, 0);

      // random phases, each under its own settings
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               thr = 16'hFFFF;
               win = 8'd255;
            end
            1: begin
               thr = 16'h0000;
               win = 8'd1;
            end
            2: begin
               thr = 16'($urandom);
               win = 8'd0;
            end
            default: begin
               thr = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4096))
                                                 : 16'($urandom);
               win = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                                 : 8'($urandom_range(1, 24));
            end
         endcase
         send_gaps = (phase != 3) && (phase < PHASES - 2);
         recv_gaps = (phase != 4) && (phase < PHASES - 2);
         configure(thr, win);
         busy_pct = $urandom_range(0, 100);
         for (count = 0; count < PHASE_ITEMS; count++) begin
            if (count % 20 == 0) busy_pct = $urandom_range(0, 100);
            send_sample(random_sample(busy_pct));
         end
      end

      // wait out the owed decisions, then watch for stray beats
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/wmd_pkg.sv
hdl/wmd_ctrl.sv
hdl/wmd_datapath.sv
hdl/windowed_motion_detector.sv
verif/tb.sv
